// ===== hdl/sst_pkg.sv =====
`default_nettype none
package sst_pkg;
  localparam int MaxLexeme = 32;
  localparam int AddrW = $clog2(MaxLexeme);
  localparam int CntW = $clog2(MaxLexeme + 1);

  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_END = 2'd1;
  localparam logic [1:0] CMD_LINE = 2'd2;

  localparam logic [2:0] K_ID = 3'd0;
  localparam logic [2:0] K_KW = 3'd1;
  localparam logic [2:0] K_INT = 3'd2;
  localparam logic [2:0] K_SYM = 3'd3;
  localparam logic [2:0] K_STR = 3'd4;
  localparam logic [2:0] K_CHR = 3'd5;
  localparam logic [2:0] K_ERR = 3'd6;
  localparam logic [2:0] K_END = 3'd7;

  localparam logic [3:0] M_START = 4'd0;
  localparam logic [3:0] M_ID = 4'd1;
  localparam logic [3:0] M_INT = 4'd2;
  localparam logic [3:0] M_SYM = 4'd3;
  localparam logic [3:0] M_STR = 4'd4;
  localparam logic [3:0] M_STR_ESC = 4'd5;
  localparam logic [3:0] M_CHR = 4'd6;
  localparam logic [3:0] M_CHR_A = 4'd7;
  localparam logic [3:0] M_CHR_B = 4'd8;
  localparam logic [3:0] M_CHR_C = 4'd9;
  localparam logic [3:0] M_COM = 4'd10;
  localparam logic [3:0] M_COM_STAR = 4'd11;
  localparam logic [3:0] M_LINE_COM = 4'd12;
  localparam logic [3:0] M_ERR = 4'd13;

  typedef struct packed {
    logic [2:0] kind;
    logic [15:0] line;
    logic [CntW-1:0] len;
    logic trunc;
    logic [7:0] first;
  } tok_t;

  function automatic logic is_alpha(input logic [7:0] b);
    logic [7:0] l;
    l = b | 8'h20;
    return l >= 8'h61 && l <= 8'h7a;
  endfunction
  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction
  function automatic logic is_blank(input logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0a;
  endfunction
  function automatic logic is_symbol(input logic [7:0] b);
    case (b)
      "{", "}", "(", ")", "[", "]", ".", ",", ";", "+", "-", "*", "/", "&",
      "|", "~", "<", ">", "=": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction
  function automatic logic is_escape(input logic [7:0] b);
    case (b)
      "a", "b", "f", "n", "r", "t", "v", "\\", "?", "'", "\"": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction
  function automatic logic is_kw(input logic [63:0] w, input logic [3:0] n);
    case (n)
      4'd2: return w[15:0] == "do" || w[15:0] == "in" || w[15:0] == "or"
          || w[15:0] == "if";
      4'd3: return w[23:0] == "and" || w[23:0] == "end" || w[23:0] == "nil"
          || w[23:0] == "not" || w[23:0] == "for";
      4'd4: return w[31:0] == "then" || w[31:0] == "true" || w[31:0] == "else";
      4'd5: return w[39:0] == "break" || w[39:0] == "local" || w[39:0] == "until"
          || w[39:0] == "false" || w[39:0] == "while";
      4'd6: return w[47:0] == "repeat" || w[47:0] == "elseif" || w[47:0] == "return";
      4'd8: return w == "function";
      default: return 1'b0;
    endcase
  endfunction
endpackage
`default_nettype wire

// ===== hdl/script_source_tokenizer.sv =====
// Streaming source tokenizer.
// Input channel: command_i/source_byte_i with valid_i, stall_o. Command 0
// feeds a source byte, 1 marks end of input, 2 restarts the line count.
// Output channel: one transfer per lexeme byte of each completed token
// (one transfer for an empty lexeme), last_of_token_o on the final one,
// with kind, start line, position, stored length and truncated flag.
// Bytes are scanned as they are accepted; the lexeme lives in a 32-entry
// RAM with registered read. A finished token is handed to the drain unit,
// which issues one RAM read and waits for its result before the next. The
// first result passes the drain's active flag, the RAM read register and
// the output register after the transfer that completes the token. Input
// is held off while reads are issued. A failed character literal rewrites
// two to four entries of its lexeme and holds input off while it does so.
// After reset the scanner is in the start state with no lexeme and a line
// count of zero; the RAM holds no defined data. When the receiver stalls,
// the current result holds and draining pauses; input is refused until
// the last read of the run is issued.
`default_nettype none
module script_source_tokenizer
  import sst_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [7:0]  source_byte_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [2:0]       token_kind_o,
  output logic [15:0]      line_number_o,
  output logic [7:0]       lexeme_byte_o,
  output logic [4:0]       byte_position_o,
  output logic [5:0]       lexeme_length_o,
  output logic             truncated_o,
  output logic             last_of_token_o
);
  logic [3:0] mode_q, mode_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [2:0] kind_q, kind_d;
  logic [15:0] lines_q, lines_d, tline_q, tline_d;
  logic ovf_q, ovf_d;
  logic [63:0] kw_q, kw_d;
  logic [7:0] c0_q, c0_d, c1_q, c1_d;
  logic busy, acc, emit;
  tok_t tok;
  logic we;
  logic [AddrW-1:0] waddr, raddr;
  logic [7:0] wdata, rdata;
  logic [7:0] b;
  logic [15:0] row;

  assign stall_o = busy;
  assign acc = valid_i && !busy;
  assign b = source_byte_i;
  assign row = (lines_q == 16'hffff) ? 16'hffff : lines_q + 16'd1;

  always_comb begin
    logic again;
    logic [2:0] tn;
    mode_d = mode_q; cnt_d = cnt_q; kind_d = kind_q; lines_d = lines_q;
    tline_d = tline_q; ovf_d = ovf_q; kw_d = kw_q; c0_d = c0_q; c1_d = c1_q;
    emit = 1'b0; tok = '0; we = 1'b0; waddr = '0; wdata = b; again = 1'b0;
    tn = '0;
    if (acc) begin
      if (command_i == CMD_BYTE) begin
        case (mode_q)
          M_ID: begin
            if (is_alpha(b) || is_digit(b) || b == "_") begin
              wdata = b; we = 1'b1;
            end else begin
              emit = 1'b1; again = 1'b1;
              tok.kind = (!ovf_q && is_kw(kw_q, 4'(cnt_q > CntW'(8) ? 0 : cnt_q)))
                  ? K_KW : K_ID;
            end
          end
          M_INT: begin
            if (is_digit(b)) we = 1'b1;
            else begin emit = 1'b1; again = 1'b1; tok.kind = K_INT; end
          end
          M_SYM: begin
            if (c0_q == "/" && b == "*") begin
              cnt_d = '0; ovf_d = 1'b0; mode_d = M_COM;
            end else if (c0_q == "/" && b == "/") begin
              cnt_d = '0; ovf_d = 1'b0; mode_d = M_LINE_COM;
            end else if ((c0_q == "<" || c0_q == "=") && b == "="
                || (c0_q == "&" && b == "&") || (c0_q == "|" && b == "|")) begin
              we = 1'b1; emit = 1'b1; tok.kind = K_SYM;
            end else begin
              emit = 1'b1; again = 1'b1; tok.kind = K_SYM;
            end
          end
          M_STR: begin
            if (b == "\"") begin emit = 1'b1; tok.kind = K_STR; end
            else begin
              if (b == "\\") mode_d = M_STR_ESC;
              we = 1'b1;
            end
          end
          M_STR_ESC: begin
            mode_d = M_STR;
            if (b == "'" && !ovf_q && cnt_q != '0) begin
              we = 1'b1; waddr = AddrW'(cnt_q - CntW'(1));
            end else we = 1'b1;
          end
          M_CHR: begin
            if (b == "'") tn = 3'd2;
            else begin
              mode_d = (b == "\\") ? M_CHR_B : M_CHR_A;
              we = 1'b1;
            end
          end
          M_CHR_A, M_CHR_C: begin
            if (b == "'") begin emit = 1'b1; tok.kind = K_CHR; end
            else tn = 3'(cnt_q) + 3'd2;
          end
          M_CHR_B: begin
            if (is_escape(b)) begin mode_d = M_CHR_C; we = 1'b1; end
            else tn = 3'(cnt_q) + 3'd2;
          end
          M_COM: if (b == "*") mode_d = M_COM_STAR;
          M_COM_STAR: mode_d = (b == "/") ? M_START : (b == "*") ? M_COM_STAR : M_COM;
          M_LINE_COM: if (b == "\n") mode_d = M_START;
          M_ERR: begin
            if (is_blank(b)) begin emit = 1'b1; tok.kind = K_ERR; end
            else we = 1'b1;
          end
          default: again = 1'b1;
        endcase
        if (we && mode_q != M_STR_ESC || we && waddr == '0 && !(b == "'" && !ovf_q
            && cnt_q != '0)) begin
          waddr = AddrW'(cnt_q);
        end
        if (mode_q == M_STR_ESC && b == "'" && !ovf_q && cnt_q != '0) begin
          waddr = AddrW'(cnt_q - CntW'(1));
        end else if (we) begin
          if (cnt_q == CntW'(MaxLexeme)) begin we = 1'b0; ovf_d = 1'b1; end
          else cnt_d = cnt_q + CntW'(1);
        end
        if (we && waddr == '0) c0_d = b;
        if (we && waddr == AddrW'(1)) c1_d = b;
        if (we && cnt_q < CntW'(8)) kw_d = {kw_q[55:0], b};
        if (emit) begin
          tok.line = tline_q; tok.len = cnt_d; tok.trunc = ovf_d; tok.first = c0_q;
          cnt_d = '0; ovf_d = 1'b0; mode_d = M_START;
        end
        if (tn != 3'd0) begin
          // Character literal failure: the rewrite is applied one entry per cycle.
          mode_d = M_ERR; kind_d = K_ERR;
          cnt_d = CntW'(tn);
          ovf_d = 1'b0;
          we = 1'b0;
          c0_d = "'";
          c1_d = (cnt_q == '0) ? b : c0_q;
        end
        if (again) begin
          tline_d = row; cnt_d = '0; ovf_d = 1'b0; we = 1'b0;
          if (is_blank(b)) mode_d = M_START;
          else begin
            we = 1'b1; waddr = '0; wdata = b; cnt_d = CntW'(1); c0_d = b;
            kw_d[7:0] = b;
            if (is_alpha(b) || b == "_") begin mode_d = M_ID; kind_d = K_ID; end
            else if (is_digit(b)) begin mode_d = M_INT; kind_d = K_INT; end
            else if (is_symbol(b)) begin mode_d = M_SYM; kind_d = K_SYM; end
            else if (b == "\"") begin
              mode_d = M_STR; kind_d = K_STR; we = 1'b0; cnt_d = '0;
            end else if (b == "'") begin
              mode_d = M_CHR; kind_d = K_CHR; we = 1'b0; cnt_d = '0;
            end else begin mode_d = M_ERR; kind_d = K_ERR; end
          end
        end
        if (b == "\n" && lines_q != 16'hffff) lines_d = lines_q + 16'd1;
      end else if (command_i == CMD_END) begin
        emit = 1'b1; tok.kind = K_END; tok.line = tline_q; tok.len = cnt_q;
        tok.trunc = ovf_q; tok.first = c0_q; cnt_d = '0; ovf_d = 1'b0; mode_d = M_START;
      end else if (command_i == CMD_LINE) begin
        lines_d = '0;
      end
    end
  end

  // Character literal failure rewrites up to four entries; sequenced here.
  logic [2:0] fix_q;
  logic [7:0] fb_q [4];
  logic fix_we;
  logic [AddrW-1:0] fix_addr;
  logic [7:0] fix_data;
  logic drain_busy;
  logic [2:0] fail_n;
  assign fail_n = (acc && command_i == CMD_BYTE && mode_d == M_ERR && mode_q != M_ERR
      && mode_q != M_START && !(mode_q == M_ID || mode_q == M_INT || mode_q == M_SYM))
      ? 3'(cnt_d) : 3'd0;
  assign fix_we = fix_q != 3'd0;
  assign fix_addr = AddrW'(3'(cnt_q) - fix_q);
  assign fix_data = fb_q[2'(3'(cnt_q) - fix_q)];
  assign busy = drain_busy || fix_we;

  sst_ram #(.Width(8), .Depth(MaxLexeme)) u_ram (
    .clk_i, .we_i(we || fix_we), .waddr_i(fix_we ? fix_addr : waddr),
    .wdata_i(fix_we ? fix_data : wdata), .raddr_i(raddr), .rdata_o(rdata)
  );

  sst_drain u_drain (
    .clk_i, .rst_ni, .start_i(emit), .tok_i(tok), .busy_o(drain_busy),
    .raddr_o(raddr), .rdata_i(rdata), .valid_o, .stall_i, .token_kind_o,
    .line_number_o, .lexeme_byte_o, .byte_position_o, .lexeme_length_o,
    .truncated_o, .last_of_token_o
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_START; cnt_q <= '0; kind_q <= '0; lines_q <= '0;
      tline_q <= '0; ovf_q <= 1'b0; fix_q <= '0;
    end else begin
      mode_q <= mode_d; cnt_q <= cnt_d; kind_q <= kind_d; lines_q <= lines_d;
      tline_q <= tline_d; ovf_q <= ovf_d;
      if (fix_we) fix_q <= fix_q - 3'd1;
      else fix_q <= fail_n;
    end
  end
  always_ff @(posedge clk_i) begin
    kw_q <= kw_d; c0_q <= c0_d; c1_q <= c1_d;
    if (fail_n != 3'd0) begin
      fb_q[0] <= "'"; fb_q[1] <= (cnt_q == '0) ? b : c0_q;
      fb_q[2] <= (cnt_q == CntW'(1)) ? b : c1_q; fb_q[3] <= b;
    end
  end

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxLexeme)) else $error("count");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> stall_o) else $error("drain");
  a_fix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fix_we |-> !acc) else $error("fix");
endmodule
`default_nettype wire

// ===== hdl/sst_ram.sv =====
`default_nettype none
module sst_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== hdl/sst_drain.sv =====
`default_nettype none
module sst_drain
  import sst_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire tok_t             tok_i,
  output logic                  busy_o,
  output logic [AddrW-1:0]      raddr_o,
  input  wire logic [7:0]       rdata_i,
  output logic                  valid_o,
  input  wire logic             stall_i,
  output logic [2:0]            token_kind_o,
  output logic [15:0]           line_number_o,
  output logic [7:0]            lexeme_byte_o,
  output logic [4:0]            byte_position_o,
  output logic [5:0]            lexeme_length_o,
  output logic                  truncated_o,
  output logic                  last_of_token_o
);
  tok_t tok_q;
  logic active_q, rd_q, valid_q;
  logic [CntW-1:0] idx_q, pos_q;
  logic [7:0] byte_q;
  logic take, issue;
  logic [CntW-1:0] n;

  assign n = (tok_q.len == '0) ? CntW'(1) : tok_q.len;
  assign take = valid_q && !stall_i;
  assign issue = active_q && (!valid_q || take) && !rd_q;
  assign busy_o = active_q;
  assign raddr_o = idx_q[AddrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      rd_q <= 1'b0;
      valid_q <= 1'b0;
      idx_q <= '0;
    end else begin
      if (take) begin
        valid_q <= 1'b0;
      end
      if (rd_q) begin
        valid_q <= 1'b1;
      end
      rd_q <= issue;
      if (start_i) begin
        active_q <= 1'b1;
        idx_q <= '0;
      end else if (issue) begin
        if (idx_q + CntW'(1) == n) begin
          active_q <= 1'b0;
        end
        idx_q <= idx_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      tok_q <= tok_i;
    end
    if (issue) begin
      pos_q <= idx_q;
    end
    if (rd_q) begin
      byte_q <= (tok_q.len == '0) ? 8'd0 : (pos_q == '0) ? tok_q.first : rdata_i;
      token_kind_o <= tok_q.kind;
      line_number_o <= tok_q.line;
      byte_position_o <= pos_q[4:0];
      lexeme_length_o <= 6'(tok_q.len);
      truncated_o <= tok_q.trunc;
      last_of_token_o <= (pos_q + CntW'(1) == n);
    end
  end
  assign lexeme_byte_o = byte_q;
  assign valid_o = valid_q;

  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> lexeme_length_o <= 6'(MaxLexeme)) else $error("length");
  a_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> !start_i) else $error("overlap");
  a_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_q |-> !valid_q || $past(take)) else $error("overrun");
endmodule
`default_nettype wire
